>>> rtl/assert_macros.svh
// assertion macros used by the framer top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock edge outside reset
`define BSF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: assertion failed");

// property checked on every clock edge, reset included
`define BSF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`else

`define BSF_ASSERT(lbl, clk, rstn, prop)
`define BSF_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> rtl/bsf_pkg.sv
// types, codes and sizes shared by the sentence framer files
`default_nettype none
package bsf_pkg;

    localparam int DEPTH      = 1024;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int DEPTH_CFG_W = 11;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [DEPTH_CFG_W-1:0] DEPTH_RESET = 11'd1024;
    localparam logic [7:0]             START_RESET = 8'h24;
    localparam logic [7:0]             NEWLINE_BYTE = 8'h0a;
    localparam logic [7:0]             NUL_BYTE     = 8'h00;

    // register indexes
    localparam logic REG_DEPTH = 1'b0;
    localparam logic REG_START = 1'b1;

    // commands
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_EDGE   = 2'd1;
    localparam logic [1:0] STAT_REJECT = 2'd2;
    localparam logic [1:0] STAT_IGNORE = 2'd3;

    // fill state codes
    localparam logic [1:0] FILL_PARTIAL = 2'd0;
    localparam logic [1:0] FILL_FULL    = 2'd1;
    localparam logic [1:0] FILL_EMPTY   = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } fsm_state_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       in_sentence;
        logic       sentence_end;
        logic [1:0] fill_state;
    } out_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] depth_eff;
        logic [7:0]       start_byte;
    } cfg_t;

endpackage
`default_nettype wire

>>> rtl/bsf_cfg_regs.sv
// apb configuration registers of the sentence framer
`default_nettype none
module bsf_cfg_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bsf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bsf_pkg::DATA_W-1:0] pwdata,
    output logic      [bsf_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output bsf_pkg::cfg_t                   cfg
);

    logic [bsf_pkg::DEPTH_CFG_W-1:0] depth_reg, depth_next;
    logic [7:0]                      start_reg, start_next;
    logic                            wr_en;
    logic                            reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        depth_next = depth_reg;
        start_next = start_reg;
        if (wr_en) begin
            case (reg_idx)
                bsf_pkg::REG_DEPTH: depth_next = pwdata[bsf_pkg::DEPTH_CFG_W-1:0];
                bsf_pkg::REG_START: start_next = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= bsf_pkg::DEPTH_RESET;
            start_reg <= bsf_pkg::START_RESET;
        end else begin
            depth_reg <= depth_next;
            start_reg <= start_next;
        end
    end

    always_comb begin
        case (reg_idx)
            bsf_pkg::REG_DEPTH:
                prdata = {{(bsf_pkg::DATA_W-bsf_pkg::DEPTH_CFG_W){1'b0}}, depth_reg};
            bsf_pkg::REG_START: prdata = {24'd0, start_reg};
            default:            prdata = '0;
        endcase
    end

    // zero acts as one, anything above the store size acts as the store size
    always_comb begin
        if (depth_reg == '0) begin
            cfg.depth_eff = bsf_pkg::CNT_W'(1);
        end else if (depth_reg > bsf_pkg::DEPTH) begin
            cfg.depth_eff = bsf_pkg::CNT_W'(bsf_pkg::DEPTH);
        end else begin
            cfg.depth_eff = bsf_pkg::CNT_W'(depth_reg);
        end
        cfg.start_byte = start_reg;
    end

endmodule
`default_nettype wire

>>> rtl/byte_fifo_sentence_framer_top.sv
// byte ring fifo with start-byte sentence framing on the read side
// push, ignored byte and rejected pull register their result in the cycle after accept
// a delivered pull registers the store read at accept, its result in the fetch state
// throughput: one item per cycle for pushes while m_ready holds; none during a pull fetch
// reset: synchronous active low; pointers zero, fill empty, sentence closed, no result
// reset: byte store is not cleared, depth 1024 and start byte '$' after reset
`default_nettype none
`include "assert_macros.svh"
module byte_fifo_sentence_framer_top (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // input items
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire bsf_pkg::in_item_t          s_data,
    // result items
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output bsf_pkg::out_item_t              m_data,
    // configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bsf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bsf_pkg::DATA_W-1:0] pwdata,
    output logic      [bsf_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    bsf_pkg::cfg_t cfg;

    bsf_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pointer increment with wrap at the active depth
    function automatic logic [bsf_pkg::PTR_W-1:0] advance(
        input logic [bsf_pkg::PTR_W-1:0] p,
        input logic [bsf_pkg::CNT_W-1:0] d
    );
        logic [bsf_pkg::CNT_W-1:0] n;
        n = {1'b0, p} + bsf_pkg::CNT_W'(1);
        return (n >= d) ? '0 : n[bsf_pkg::PTR_W-1:0];
    endfunction

    // control and fifo state
    bsf_pkg::fsm_state_t             state_reg, state_next;
    logic [bsf_pkg::PTR_W-1:0]       wp_reg, wp_next;
    logic [bsf_pkg::PTR_W-1:0]       rp_reg, rp_next;
    logic [1:0]                      occ_reg, occ_next;
    logic                            open_reg, open_next;
    logic                            m_valid_reg, m_valid_next;
    bsf_pkg::out_item_t              m_data_reg, m_data_next;

    // byte store, one write port and two read ports (current entry and peek)
    logic [7:0]                      store_mem [bsf_pkg::DEPTH];
    logic [7:0]                      rd_cur_reg;
    logic [7:0]                      rd_peek_reg;

    logic                            out_free;
    logic                            accept;
    logic                            is_pull;
    logic                            rd_en;
    logic                            wr_en;
    logic                            finish_pull;
    logic [bsf_pkg::PTR_W-1:0]       wp_adv;
    logic [bsf_pkg::PTR_W-1:0]       rp_adv;
    logic                            peek_start;

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_pull  = (s_data.command == bsf_pkg::CMD_PULL);
    assign wp_adv   = advance(wp_reg, cfg.depth_eff);
    assign rp_adv   = advance(rp_reg, cfg.depth_eff);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bsf_pkg::ST_IDLE: begin
                if (accept && is_pull && occ_reg != bsf_pkg::FILL_EMPTY) begin
                    state_next = bsf_pkg::ST_FETCH;
                end
            end
            bsf_pkg::ST_FETCH: begin
                if (out_free) begin
                    state_next = bsf_pkg::ST_IDLE;
                end
            end
            default: state_next = bsf_pkg::ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        s_ready     = 1'b0;
        finish_pull = 1'b0;
        case (state_reg)
            bsf_pkg::ST_IDLE:  s_ready     = out_free;
            bsf_pkg::ST_FETCH: finish_pull = out_free;
            default: ;
        endcase
    end

    // a pull issues both reads at accept; the read data waits in the fetch state
    assign rd_en = accept && is_pull && (occ_reg != bsf_pkg::FILL_EMPTY);
    assign wr_en = accept && !is_pull && (s_data.data_byte != bsf_pkg::NUL_BYTE)
                   && (s_data.data_byte != bsf_pkg::NEWLINE_BYTE)
                   && (occ_reg != bsf_pkg::FILL_FULL);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wp_reg] <= s_data.data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_cur_reg  <= store_mem[rp_reg];
            rd_peek_reg <= store_mem[rp_adv];
        end
    end

    // peek counts as no start byte when this pull empties the fifo
    assign peek_start = (rp_adv != wp_reg) && (rd_peek_reg == cfg.start_byte);

    // datapath: pointer, fill, sentence and result updates
    always_comb begin
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        occ_next     = occ_reg;
        open_next    = open_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (accept && !is_pull) begin
            m_data_next  = '0;
            m_valid_next = 1'b1;
            if (s_data.data_byte == bsf_pkg::NUL_BYTE
                || s_data.data_byte == bsf_pkg::NEWLINE_BYTE) begin
                m_data_next.status = bsf_pkg::STAT_IGNORE;
            end else if (occ_reg == bsf_pkg::FILL_FULL) begin
                m_data_next.status = bsf_pkg::STAT_REJECT;
            end else begin
                wp_next = wp_adv;
                if (wp_adv == rp_reg) begin
                    occ_next           = bsf_pkg::FILL_FULL;
                    m_data_next.status = bsf_pkg::STAT_EDGE;
                end else begin
                    occ_next           = bsf_pkg::FILL_PARTIAL;
                    m_data_next.status = bsf_pkg::STAT_DONE;
                end
            end
            m_data_next.fill_state = occ_next;
        end else if (accept && is_pull && occ_reg == bsf_pkg::FILL_EMPTY) begin
            // rejected pull closes any open sentence
            m_data_next            = '0;
            m_valid_next           = 1'b1;
            m_data_next.status     = bsf_pkg::STAT_REJECT;
            m_data_next.fill_state = bsf_pkg::FILL_EMPTY;
            open_next              = 1'b0;
        end else if (finish_pull) begin
            m_data_next            = '0;
            m_valid_next           = 1'b1;
            m_data_next.byte_valid = 1'b1;
            m_data_next.out_byte   = rd_cur_reg;
            rp_next                = rp_adv;
            if (rp_adv == wp_reg) begin
                occ_next           = bsf_pkg::FILL_EMPTY;
                m_data_next.status = bsf_pkg::STAT_EDGE;
            end else begin
                occ_next           = bsf_pkg::FILL_PARTIAL;
                m_data_next.status = bsf_pkg::STAT_DONE;
            end
            m_data_next.fill_state = occ_next;
            if (!open_reg) begin
                // only a start byte opens; the opening byte never ends
                if (rd_cur_reg == cfg.start_byte) begin
                    open_next               = 1'b1;
                    m_data_next.in_sentence = 1'b1;
                end
            end else begin
                m_data_next.in_sentence = 1'b1;
                if (peek_start) begin
                    m_data_next.sentence_end = 1'b1;
                    open_next                = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bsf_pkg::ST_IDLE;
            wp_reg      <= '0;
            rp_reg      <= '0;
            occ_reg     <= bsf_pkg::FILL_EMPTY;
            open_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            occ_reg     <= occ_next;
            open_reg    <= open_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // pointers meet exactly when the fifo is full or empty
    `BSF_ASSERT(a_ptr_meet, aclk, aresetn,
        (wp_reg == rp_reg) == (occ_reg != bsf_pkg::FILL_PARTIAL))
    // no new item while a pull waits on its store read
    `BSF_ASSERT(a_fetch_blocks, aclk, aresetn,
        (state_reg == bsf_pkg::ST_FETCH) |-> !s_ready)
    // the store is written only from the idle state
    `BSF_ASSERT(a_write_idle, aclk, aresetn,
        wr_en |-> (state_reg == bsf_pkg::ST_IDLE))
    // a delivered byte comes only with a done or edge status
    `BSF_ASSERT(a_byte_status, aclk, aresetn,
        (m_valid && m_data.byte_valid) |->
            (m_data.status == bsf_pkg::STAT_DONE || m_data.status == bsf_pkg::STAT_EDGE))
    // a sentence end is always inside a sentence
    `BSF_ASSERT(a_end_in_sentence, aclk, aresetn,
        (m_valid && m_data.sentence_end) |-> m_data.in_sentence)

endmodule
`default_nettype wire
